@@ rtl/core/alcf_pkg.sv @@
// ----------------------------------------------------------------------------
// alcf_pkg: shared definitions for the loss concealment fade unit
// Widths, register indexes, mode and status codes, Q1.15 constants.
// ----------------------------------------------------------------------------
package alcf_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int LOSS_BITS_DEF   = 8;

  localparam int SEQ_BITS      = 32;
  localparam int FADE_BITS     = 16;
  localparam int MODE_BITS     = 2;
  localparam int FRAC_BITS     = 15;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [FADE_BITS-1:0] UNITY_Q15  = 16'h8000;
  localparam logic [FADE_BITS-1:0] FADE_RESET = 16'd29491;

  // config register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODE = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FADE = 1'b1;

  // concealment modes (code 3 acts as repeat)
  localparam logic [MODE_BITS-1:0] MODE_ZERO   = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_REPEAT = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_FADE   = 2'd2;

  localparam logic ACT_HEADER = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_NO_REF = 1'b1;

endpackage

@@ rtl/core/alcf_intf.sv @@
// ----------------------------------------------------------------------------
// alcf_intf: valid/ready channels of the loss concealment fade unit
// Input word, result word and configuration write channel.
// ----------------------------------------------------------------------------
interface alcf_in_if
  import alcf_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int LOSS_BITS   = LOSS_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic        [LOSS_BITS-1:0]   loss_count;
  logic        [SEQ_BITS-1:0]    base_seq;
  logic                          have_reference;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last_sample;

  modport source (output valid, action, loss_count, base_seq, have_reference, sample,
                  last_sample, input ready);
  modport sink   (input valid, action, loss_count, base_seq, have_reference, sample,
                  last_sample, output ready);
endinterface

interface alcf_out_if
  import alcf_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic        [SEQ_BITS-1:0]    seq_out;
  logic                          status;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          last_out;

  modport source (output valid, seq_out, status, sample_out, last_out, input ready);
  modport sink   (input valid, seq_out, status, sample_out, last_out, output ready);
endinterface

interface alcf_cfg_if
  import alcf_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/audio_loss_concealment_fade_unit.sv @@
// ----------------------------------------------------------------------------
// audio_loss_concealment_fade_unit: stand-in frames for lost audio packets
// Header words set the concealment sequence number and fade gain; sample
// words come back zeroed, repeated or faded.
// ----------------------------------------------------------------------------
// One word is in flight at a time; in_i.ready is high only while idle. For a
// header word the fade gain is built in ST_GAIN by one shared multiplier, one
// Q1.15 multiply per lost packet. A sample word goes straight to ST_PUSH in
// zero or repeat mode; in fade mode the same multiplier scales the sample in
// ST_MUL and ST_SAT then truncates and saturates. The result sits in an
// output register, so the next word is taken while the previous result
// still waits on out_o.ready.
module audio_loss_concealment_fade_unit
  import alcf_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int LOSS_BITS   = LOSS_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  alcf_in_if.sink    in_i,
  alcf_out_if.source out_o,
  alcf_cfg_if.sink   cfg_i
);

  localparam int MUL_A_W = (SAMPLE_BITS > FADE_BITS + 1) ? SAMPLE_BITS : FADE_BITS + 1;
  localparam int PW      = MUL_A_W + FADE_BITS + 1;
  localparam int QW      = PW - FRAC_BITS;

  localparam logic signed [QW-1:0] SAT_HI = QW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [QW-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [PW-1:0] TRUNC_BIAS = PW'((64'sd1 <<< FRAC_BITS) - 64'sd1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAIN,
    ST_MUL,
    ST_SAT,
    ST_PUSH
  } state_e;

  // configuration
  logic [MODE_BITS-1:0] mode_q;
  logic [FADE_BITS-1:0] fade_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_REPEAT;
      fade_q <= FADE_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_MODE: mode_q <= cfg_i.data[MODE_BITS-1:0];
        CFG_FADE: fade_q <= cfg_i.data[FADE_BITS-1:0];
        default: ;
      endcase
    end
  end

  state_e                        state_q;
  logic        [LOSS_BITS-1:0]   cnt_q;
  logic        [FADE_BITS-1:0]   gain_q;
  logic        [FADE_BITS-1:0]   fade_eff_q;
  logic                          frame_err_q;
  logic signed [SAMPLE_BITS-1:0] samp_q;
  logic signed [PW-1:0]          prod_q;

  logic        [SEQ_BITS-1:0]    res_seq_q;
  logic                          res_status_q;
  logic signed [SAMPLE_BITS-1:0] res_sample_q;
  logic                          res_last_q;

  logic                          out_valid_q;
  logic        [SEQ_BITS-1:0]    out_seq_q;
  logic                          out_status_q;
  logic signed [SAMPLE_BITS-1:0] out_sample_q;
  logic                          out_last_q;

  // shared multiplier: gain * fade while building the gain, sample * gain in fade mode
  logic signed [MUL_A_W-1:0]   mul_a;
  logic signed [FADE_BITS:0]   mul_b;
  logic signed [PW-1:0]        mul_p;

  always_comb begin
    if (state_q == ST_GAIN) begin
      mul_a = $signed({{(MUL_A_W - FADE_BITS){1'b0}}, gain_q});
      mul_b = $signed({1'b0, fade_eff_q});
    end else begin
      mul_a = MUL_A_W'(samp_q);
      mul_b = $signed({1'b0, gain_q});
    end
    mul_p = PW'(mul_a) * PW'(mul_b);
  end

  // truncate toward zero, then clamp to the sample range
  logic signed [PW-1:0]          trunc_sum;
  logic signed [QW-1:0]          scaled;
  logic signed [SAMPLE_BITS-1:0] sat_val;

  always_comb begin
    trunc_sum = prod_q + (prod_q[PW-1] ? TRUNC_BIAS : '0);
    scaled    = $signed(trunc_sum[PW-1:FRAC_BITS]);
    if (scaled > SAT_HI) begin
      sat_val = SAT_HI[SAMPLE_BITS-1:0];
    end else if (scaled < SAT_LO) begin
      sat_val = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      sat_val = scaled[SAMPLE_BITS-1:0];
    end
  end

  assign in_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gain_q      <= UNITY_Q15;
      frame_err_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // in ST_PUSH the push below owns out_valid_q
      if (out_valid_q && out_o.ready && state_q != ST_PUSH) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            if (in_i.action == ACT_HEADER) begin
              cnt_q        <= in_i.loss_count;
              gain_q       <= UNITY_Q15;
              fade_eff_q   <= (fade_q > UNITY_Q15) ? UNITY_Q15 : fade_q;
              frame_err_q  <= !in_i.have_reference;
              res_seq_q    <= in_i.have_reference ?
                              in_i.base_seq + SEQ_BITS'(in_i.loss_count) : '0;
              res_status_q <= in_i.have_reference ? STATUS_OK : STATUS_NO_REF;
              res_sample_q <= '0;
              res_last_q   <= 1'b0;
              state_q      <= (in_i.loss_count == '0) ? ST_PUSH : ST_GAIN;
            end else begin
              samp_q       <= in_i.sample;
              res_seq_q    <= '0;
              res_status_q <= frame_err_q ? STATUS_NO_REF : STATUS_OK;
              res_last_q   <= in_i.last_sample;
              if (frame_err_q) begin
                res_sample_q <= '0;
                state_q      <= ST_PUSH;
              end else begin
                case (mode_q)
                  MODE_ZERO: begin
                    res_sample_q <= '0;
                    state_q      <= ST_PUSH;
                  end
                  MODE_FADE: begin
                    state_q <= ST_MUL;
                  end
                  default: begin
                    res_sample_q <= in_i.sample;
                    state_q      <= ST_PUSH;
                  end
                endcase
              end
            end
          end
        end
        ST_GAIN: begin
          gain_q <= mul_p[FRAC_BITS+FADE_BITS-1:FRAC_BITS];
          cnt_q  <= cnt_q - LOSS_BITS'(1);
          if (cnt_q == LOSS_BITS'(1)) begin
            state_q <= ST_PUSH;
          end
        end
        ST_MUL: begin
          prod_q  <= mul_p;
          state_q <= ST_SAT;
        end
        ST_SAT: begin
          res_sample_q <= sat_val;
          state_q      <= ST_PUSH;
        end
        ST_PUSH: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q  <= 1'b1;
            out_seq_q    <= res_seq_q;
            out_status_q <= res_status_q;
            out_sample_q <= res_sample_q;
            out_last_q   <= res_last_q;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.seq_out    = out_seq_q;
  assign out_o.status     = out_status_q;
  assign out_o.sample_out = out_sample_q;
  assign out_o.last_out   = out_last_q;

endmodule

@@ rtl/core/alcf_checker.sv @@
// ----------------------------------------------------------------------------
// alcf_checker: port-level checks for the loss concealment fade unit
// Bound to the top level; watches the input and result channels.
// ----------------------------------------------------------------------------
module alcf_checker
  import alcf_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic        [SEQ_BITS-1:0]    out_seq_i,
  input logic                          out_status_i,
  input logic signed [SAMPLE_BITS-1:0] out_sample_i,
  input logic                          out_last_i
);

  // a waiting result word stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_sample_i) && $stable(out_seq_i))
    else $error("result word dropped or changed while stalled");

  // one word in flight: ready drops right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while a word is in flight");

  // missing reference: no sequence number, silent samples
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == STATUS_NO_REF) |-> out_seq_i == '0 && out_sample_i == '0)
    else $error("errored result carries data");

  // a sequence number only ever comes with a clean header result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_seq_i != '0 |-> out_sample_i == '0 && !out_last_i &&
                                        out_status_i == STATUS_OK)
    else $error("header result mixed with sample fields");

endmodule

bind audio_loss_concealment_fade_unit alcf_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_alcf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_seq_i   (out_o.seq_out),
  .out_status_i(out_o.status),
  .out_sample_i(out_o.sample_out),
  .out_last_i  (out_o.last_out)
);

@@ sim/alcf_fade_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alcf_fade_checker: result checker for the loss concealment fade unit
// Watches the input, result and configuration channels. It keeps its own
// copy of the mode, fade factor, gain and frame error state and predicts one
// result word per accepted input word. It then compares each accepted result
// word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module alcf_fade_checker
  import alcf_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int LOSS_BITS   = LOSS_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  alcf_in_if          in_i,
  alcf_out_if         out_i,
  alcf_cfg_if         cfg_i,
  output int unsigned fails_o,
  output int unsigned pending_o,
  output int unsigned words_done_o
);

  typedef struct {
    logic [SEQ_BITS-1:0]    seq;
    logic                   status;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;
  } conceal_word_t;

  conceal_word_t          conceal_q[$];
  logic [MODE_BITS-1:0]   mode_r;
  logic [FADE_BITS-1:0]   fade_r;
  logic [FADE_BITS-1:0]   gain_r;
  logic                   frame_err_r;
  int unsigned            fail_cnt;
  int unsigned            done_cnt;

  // fade^losses in Q1.15, truncated after every multiply
  function automatic logic [FADE_BITS-1:0] fade_gain(input logic [LOSS_BITS-1:0] losses,
                                                     input logic [FADE_BITS-1:0] fade);
    logic [31:0]          g;
    logic [FADE_BITS-1:0] f;
    f = (fade > UNITY_Q15) ? UNITY_Q15 : fade;
    g = 32'(UNITY_Q15);
    for (int k = 0; k < int'(losses); k++) g = (g * 32'(f)) >> FRAC_BITS;
    return g[FADE_BITS-1:0];
  endfunction

  // sample * gain, truncated toward zero, saturated to the sample range
  function automatic logic [SAMPLE_BITS-1:0] faded_sample(input logic [SAMPLE_BITS-1:0] s,
                                                          input logic [FADE_BITS-1:0] g);
    longint p;
    longint q;
    longint hi;
    longint lo;
    p  = longint'($signed(s)) * longint'({1'b0, g});
    hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    lo = -hi - 1;
    q  = (p < 0) ? -((-p) >>> FRAC_BITS) : (p >>> FRAC_BITS);
    if (q > hi) q = hi;
    if (q < lo) q = lo;
    return q[SAMPLE_BITS-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : mon
    conceal_word_t exp_w;
    conceal_word_t new_w;
    if (!rst_ni) begin
      mode_r      = MODE_REPEAT;
      fade_r      = FADE_RESET;
      gain_r      = UNITY_Q15;
      frame_err_r = 1'b0;
      conceal_q.delete();
      fail_cnt    = 0;
      done_cnt    = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == CFG_MODE) mode_r = cfg_i.data[MODE_BITS-1:0];
        else if (cfg_i.index == CFG_FADE) fade_r = cfg_i.data[FADE_BITS-1:0];
      end

      if (in_i.valid && in_i.ready) begin
        if (in_i.action == ACT_HEADER) begin
          // gain is rebuilt even when the reference is missing
          gain_r      = fade_gain(in_i.loss_count, fade_r);
          frame_err_r = !in_i.have_reference;
          new_w.seq    = in_i.have_reference ? in_i.base_seq + SEQ_BITS'(in_i.loss_count) : '0;
          new_w.status = in_i.have_reference ? STATUS_OK : STATUS_NO_REF;
          new_w.sample = '0;
          new_w.last   = 1'b0;
        end else begin
          new_w.seq    = '0;
          new_w.status = frame_err_r ? STATUS_NO_REF : STATUS_OK;
          if (frame_err_r || mode_r == MODE_ZERO) new_w.sample = '0;
          else if (mode_r == MODE_FADE) new_w.sample = faded_sample(in_i.sample, gain_r);
          else new_w.sample = in_i.sample;
          new_w.last   = in_i.last_sample;
        end
        conceal_q.push_back(new_w);
      end

      if (out_i.valid && out_i.ready) begin
        done_cnt++;
        if (conceal_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_cnt++;
        end else begin
          exp_w = conceal_q.pop_front();
          if (out_i.seq_out !== exp_w.seq) begin
            $error("seq_out: expected %0h, got %0h", exp_w.seq, out_i.seq_out);
            fail_cnt++;
          end
          if (out_i.status !== exp_w.status) begin
            $error("status: expected %0d, got %0d", exp_w.status, out_i.status);
            fail_cnt++;
          end
          if (out_i.sample_out !== exp_w.sample) begin
            $error("sample_out: expected %0d, got %0d", $signed(exp_w.sample),
                   $signed(out_i.sample_out));
            fail_cnt++;
          end
          if (out_i.last_out !== exp_w.last) begin
            $error("last_out: expected %0d, got %0d", exp_w.last, out_i.last_out);
            fail_cnt++;
          end
        end
      end
    end
    fails_o      <= fail_cnt;
    pending_o    <= conceal_q.size();
    words_done_o <= done_cnt;
  end

endmodule

@@ sim/tb_audio_loss_concealment_fade_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_loss_concealment_fade_unit: testbench for the fade unit
// Drives header and sample words with random gaps, random result stalls
// and one long result hold-off. It steps through mode and fade factor
// settings while the unit is idle. Checking is done by alcf_fade_checker.
// ----------------------------------------------------------------------------
module tb_audio_loss_concealment_fade_unit;
  import alcf_pkg::*;

  localparam int SAMPLE_BITS    = SAMPLE_BITS_DEF;
  localparam int LOSS_BITS      = LOSS_BITS_DEF;
  localparam int CLK_PERIOD     = 10;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int TAIL_CYCLES    = 300;  // longer than a 255-loss header
  localparam int LONG_HOLD      = 300;
  localparam int RAND_PHASES    = 10;
  localparam int PHASE_WORDS    = 40;
  localparam int HOLD_PHASE     = 3;
  // undefined mode code, handled as repeat
  localparam logic [MODE_BITS-1:0] MODE_ALIAS = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        calm = 1'b0;
  logic        hold_off_req = 1'b0;
  int unsigned words_sent = 0;
  int unsigned fails;
  int unsigned pending;
  int unsigned words_done;

  alcf_in_if  #(.SAMPLE_BITS(SAMPLE_BITS), .LOSS_BITS(LOSS_BITS)) in_w ();
  alcf_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_w ();
  alcf_cfg_if cfg_w ();

  audio_loss_concealment_fade_unit #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .LOSS_BITS  (LOSS_BITS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_w),
    .out_o (out_w),
    .cfg_i (cfg_w)
  );

  alcf_fade_checker #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .LOSS_BITS  (LOSS_BITS)
  ) chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_w),
    .out_i       (out_w),
    .cfg_i       (cfg_w),
    .fails_o     (fails),
    .pending_o   (pending),
    .words_done_o(words_done)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // valid stays high across back-to-back words; it only drops for a gap or in drain()
  task automatic send_word(input logic act, input logic [LOSS_BITS-1:0] losses,
                           input logic [SEQ_BITS-1:0] base, input logic have_ref,
                           input logic [SAMPLE_BITS-1:0] smp, input logic last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_w.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_w.valid          <= 1'b1;
    in_w.action         <= act;
    in_w.loss_count     <= losses;
    in_w.base_seq       <= base;
    in_w.have_reference <= have_ref;
    in_w.sample         <= smp;
    in_w.last_sample    <= last;
    @(posedge clk);
    while (!in_w.ready) @(posedge clk);
    words_sent++;
  endtask

  // sample fields of a header word are don't-care and get random values
  task automatic send_header(input logic [LOSS_BITS-1:0] losses,
                             input logic [SEQ_BITS-1:0] base, input logic have_ref);
    send_word(ACT_HEADER, losses, base, have_ref, SAMPLE_BITS'($urandom), 1'($urandom));
  endtask

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp, input logic last);
    send_word(ACT_SAMPLE, LOSS_BITS'($urandom), SEQ_BITS'($urandom), 1'($urandom), smp, last);
  endtask

  // stop sending and wait until every result word is back
  task automatic drain();
    in_w.valid <= 1'b0;
    wait (words_done == words_sent);
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_BITS-1:0] mode_data,
                           input logic [CFG_DATA_BITS-1:0] fade_data);
    drain();
    cfg_w.valid <= 1'b1;
    cfg_w.index <= CFG_MODE;
    cfg_w.data  <= mode_data;
    @(posedge clk);
    while (!cfg_w.ready) @(posedge clk);
    cfg_w.index <= CFG_FADE;
    cfg_w.data  <= fade_data;
    @(posedge clk);
    while (!cfg_w.ready) @(posedge clk);
    cfg_w.valid <= 1'b0;
  endtask

  function automatic logic [LOSS_BITS-1:0] rand_losses();
    int unsigned r;
    r = $urandom_range(0, 49);
    if (r == 0) return '1;
    if (r < 3) return LOSS_BITS'($urandom);
    return LOSS_BITS'($urandom_range(0, 9));
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      1: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // result side: random ready bursts, one long hold-off on request
  initial begin
    out_w.ready <= 1'b0;
    wait (rst_n);
    forever begin
      if (hold_off_req) begin
        out_w.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_w.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_w.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    logic [CFG_DATA_BITS-1:0] mode_data;
    logic [CFG_DATA_BITS-1:0] fade_data;
    int unsigned              phase_end;
    int unsigned              nsamp;
    int unsigned              pick;

    rst_n               <= 1'b0;
    in_w.valid          <= 1'b0;
    in_w.action         <= ACT_HEADER;
    in_w.loss_count     <= '0;
    in_w.base_seq       <= '0;
    in_w.have_reference <= 1'b0;
    in_w.sample         <= '0;
    in_w.last_sample    <= 1'b0;
    cfg_w.valid         <= 1'b0;
    cfg_w.index         <= CFG_MODE;
    cfg_w.data          <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: repeat mode, unity gain before any header
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    send_header(8'd0, 32'hFFFF_FFFF, 1'b1);
    send_sample(16'hFFFF, 1'b1);
    send_header(8'd255, 32'hFFFF_FF80, 1'b1);  // sequence wraps
    send_sample(16'h1234, 1'b1);

    configure(CFG_DATA_BITS'(MODE_FADE), FADE_RESET);
    send_sample(16'h8000, 1'b0);
    send_header(8'd1, 32'd100, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'hFFFF, 1'b0);  // -1 truncates to zero
    send_sample(16'h0001, 1'b1);
    send_header(8'd0, 32'd0, 1'b1);
    send_sample(16'h8000, 1'b1);

    // fade factor above unity is clamped
    configure(CFG_DATA_BITS'(MODE_FADE), 16'hFFFF);
    send_header(8'd200, 32'h8000_0000, 1'b1);
    send_sample(16'h8000, 1'b1);

    configure(CFG_DATA_BITS'(MODE_FADE), 16'h0000);
    send_header(8'd1, 32'd5, 1'b1);
    send_sample(16'h7FFF, 1'b1);

    configure(CFG_DATA_BITS'(MODE_ZERO), UNITY_Q15);
    send_header(8'd3, 32'd7, 1'b1);
    send_sample(16'h3039, 1'b1);
    send_header(8'd5, 32'd77, 1'b0);
    send_sample(16'h7FFF, 1'b1);

    // errored frame still zeroes samples in the alias mode
    configure({{(CFG_DATA_BITS-MODE_BITS){1'b1}}, MODE_ALIAS}, UNITY_Q15);
    send_sample(16'h8000, 1'b1);
    send_header(8'd2, 32'hFFFF_FFFE, 1'b1);
    send_sample(16'hFFF9, 1'b1);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      mode_data = CFG_DATA_BITS'($urandom);
      mode_data[MODE_BITS-1:0] = MODE_BITS'($urandom_range(0, 3));
      case ($urandom_range(0, 5))
        0: fade_data = '0;
        1: fade_data = UNITY_Q15;
        2: fade_data = '1;
        3: fade_data = CFG_DATA_BITS'($urandom);
        default: fade_data = CFG_DATA_BITS'($urandom_range(16000, 32768));
      endcase
      if (ph == RAND_PHASES - 1) calm = 1'b1;
      configure(mode_data, fade_data);
      if (ph == HOLD_PHASE) hold_off_req = 1'b1;
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) begin
        pick = $urandom_range(0, 19);
        if (pick < 17) begin
          send_header(rand_losses(), SEQ_BITS'($urandom), $urandom_range(0, 9) != 0);
          nsamp = $urandom_range(1, 8);
          for (int k = 1; k <= nsamp; k++) send_sample(rand_sample(), k == nsamp);
        end else if (pick < 19) begin
          send_sample(rand_sample(), 1'($urandom));
        end else begin
          send_header(rand_losses(), SEQ_BITS'($urandom), 1'($urandom));
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ audio_loss_concealment_fade_unit.f @@
rtl/core/alcf_pkg.sv
rtl/core/alcf_intf.sv
rtl/core/audio_loss_concealment_fade_unit.sv
rtl/core/alcf_checker.sv
sim/alcf_fade_checker.sv
sim/tb_audio_loss_concealment_fade_unit.sv
